// ===== sv/agkf_pkg.sv =====
// agkf_pkg: shared types, codes and fixed-point helpers for the angle/gyro-bias kalman filter
// no dependencies; imported by the top level and its checker

package agkf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DT_BITS   = 24;
    localparam int WORD_W    = 32;
    localparam int VAR_W     = 31;
    localparam int OPND_W    = WORD_W + 1;
    localparam int PROD_W    = 2 * OPND_W;
    localparam int WIDE_W    = PROD_W + 2;
    localparam int ACC_W     = WORD_W + 4;
    localparam int NUM_W     = WORD_W + FRAC_BITS;
    localparam int CNT_W     = $clog2(NUM_W);
    localparam int DT2_W     = DT_BITS + 1;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_INIT   = 1'b1;

    localparam logic [1:0] CFG_MEAS_VAR = 2'd0;
    localparam logic [1:0] CFG_GYRO_VAR = 2'd1;
    localparam logic [1:0] CFG_DT       = 2'd2;
    localparam logic [1:0] CFG_BIAS     = 2'd3;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [WIDE_W-1:0] t_wide;

    typedef struct packed {
        logic  flag;
        t_word val;
    } t_sat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_DIV_END,
        ST_MUL,
        ST_USE,
        ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_ANG,
        OP_BIAS,
        OP_P00,
        OP_P01,
        OP_P10,
        OP_P11,
        OP_PRED,
        OP_M,
        OP_ACC_P10,
        OP_ACC_M,
        OP_DT2,
        OP_Q
    } t_op;

    localparam t_wide SAT_MAX = {{(WIDE_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
    localparam t_wide SAT_MIN = {{(WIDE_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}};

    // clip to 32-bit signed
    function automatic t_sat sat32(input t_wide v);
        t_sat r;
        if (v > SAT_MAX) begin
            r.flag = 1'b1;
            r.val  = t_word'(SAT_MAX);
        end else if (v < SAT_MIN) begin
            r.flag = 1'b1;
            r.val  = t_word'(SAT_MIN);
        end else begin
            r.flag = 1'b0;
            r.val  = t_word'(v);
        end
        return r;
    endfunction

    // drop n fraction bits, round to nearest, ties away from zero
    function automatic logic signed [PROD_W-1:0] rshr(input logic signed [PROD_W-1:0] v,
                                                      input int unsigned n);
        logic [PROD_W:0] mag;
        logic [PROD_W:0] half;
        logic [PROD_W:0] sh;
        half = (PROD_W+1)'(1) << (n - 1);
        mag  = v[PROD_W-1] ? (PROD_W+1)'(-{v[PROD_W-1], v}) : {1'b0, v};
        sh   = (mag + half) >> n;
        return v[PROD_W-1] ? $signed(-sh[PROD_W-1:0]) : $signed(sh[PROD_W-1:0]);
    endfunction

endpackage

// ===== sv/angle_gyro_bias_kalman_filter_top.sv =====
// Two-state kalman filter for tilt angle and gyro offset, Q16.16 values, dt in Q0.24.
// One shared 33x33 multiplier and a 1-bit-per-cycle divider run under a sequencer.
// Depends on agkf_pkg.

// Usage: an update transaction (command 0) carries the accelerometer angle and the gyro rate
// and returns the corrected angle and gyro offset; it runs two restoring divisions with 48-bit
// quotients for the gains (each followed by a step to sign and clip the quotient) and twelve
// products on the shared multiplier, each a multiply and a use step. When the innovation
// variance is not positive the divisions are skipped. An initialize transaction (command 1)
// shows its result on the next cycle. The block takes one transaction at a time: the input is
// stalled from acceptance until the result has been taken. Configuration registers are
// written through their own port, only while idle: a rule for the user, not enforced.

module angle_gyro_bias_kalman_filter_top
    import agkf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_command,
    input  t_word       i_measured_angle,
    input  t_word       i_gyro_rate,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_word       o_est_angle,
    output t_word       o_est_bias,
    output logic        o_saturated
);

    t_state r_state, n_state;
    t_op    r_op, n_op;

    logic [VAR_W-1:0]   r_meas, r_gyro;
    logic [DT_BITS-1:0] r_dt;
    t_word              r_ibias;

    t_word r_pa, n_pa, r_pb, n_pb;
    t_word r_c00, n_c00, r_c01, n_c01, r_c10, n_c10, r_c11, n_c11;

    t_word r_g0, n_g0, r_g1, n_g1, r_d, n_d, r_u, n_u;
    t_word r_ang, n_ang, r_bias, n_bias;
    t_word r_p00, n_p00, r_p01, n_p01, r_p10, n_p10, r_p11, n_p11;
    logic signed [OPND_W-1:0] r_m, n_m;
    logic [DT2_W-1:0]         r_dt2, n_dt2;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic                     r_sat, n_sat;
    logic signed [PROD_W-1:0] r_prod;

    logic [WORD_W-1:0] r_rem, n_rem, r_den, n_den;
    logic [NUM_W-1:0]  r_quo, n_quo;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_neg, n_neg, r_div_g1, n_div_g1;

    logic                     w_in_acc, w_cfg_we, w_s_pos, w_ge;
    t_wide                    w_s, w_sum, w_qx;
    t_sat                     w_st, w_st_m;
    logic [WORD_W:0]          w_t;
    logic signed [OPND_W-1:0] w_opa, w_opb;
    logic signed [PROD_W-1:0] w_r16, w_r24;
    logic signed [ACC_W-1:0]  w_acc_q;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;
    assign w_in_acc    = i_in_valid && (r_state == ST_IDLE);

    assign w_s     = WIDE_W'(r_c00) + WIDE_W'({1'b0, r_meas});
    assign w_s_pos = (w_s > t_wide'(0));

    assign w_r16   = rshr(r_prod, FRAC_BITS);
    assign w_r24   = rshr(r_prod, DT_BITS);
    assign w_acc_q = r_acc + ACC_W'(w_r24);
    assign w_st_m  = sat32(WIDE_W'(r_m));

    assign w_t  = {r_rem, r_quo[NUM_W-1]};
    assign w_ge = (w_t >= {1'b0, r_den});
    assign w_qx = $signed({{(WIDE_W-NUM_W){1'b0}}, r_quo});

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_command == CMD_INIT) begin
                        n_state = ST_DONE;
                    end else if (w_s_pos) begin
                        n_state = ST_DIV;
                    end else begin
                        n_state = ST_MUL;
                    end
                end
            end
            ST_DIV: begin
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    n_state = ST_DIV_END;
                end
            end
            ST_DIV_END: begin
                n_state = r_div_g1 ? ST_MUL : ST_DIV;
            end
            ST_MUL: begin
                n_state = ST_USE;
            end
            ST_USE: begin
                n_state = (r_op == OP_Q) ? ST_DONE : ST_MUL;
            end
            ST_DONE: begin
                if (!i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        o_in_stall  = (r_state != ST_IDLE);
        o_out_valid = (r_state == ST_DONE);
    end

    assign o_est_angle = r_ang;
    assign o_est_bias  = r_bias;
    assign o_saturated = r_sat;

    // shared multiplier operands
    always_comb begin
        w_opa = '0;
        w_opb = '0;
        unique case (r_op)
            OP_ANG: begin
                w_opa = OPND_W'(r_g0);
                w_opb = OPND_W'(r_d);
            end
            OP_BIAS: begin
                w_opa = OPND_W'(r_g1);
                w_opb = OPND_W'(r_d);
            end
            OP_P00: begin
                w_opa = OPND_W'(r_g0);
                w_opb = OPND_W'(r_c00);
            end
            OP_P01: begin
                w_opa = OPND_W'(r_g0);
                w_opb = OPND_W'(r_c01);
            end
            OP_P10: begin
                w_opa = OPND_W'(r_g1);
                w_opb = OPND_W'(r_c00);
            end
            OP_P11: begin
                w_opa = OPND_W'(r_g1);
                w_opb = OPND_W'(r_c01);
            end
            OP_PRED: begin
                w_opa = $signed({{(OPND_W-DT_BITS){1'b0}}, r_dt});
                w_opb = OPND_W'(r_u) - OPND_W'(r_bias);
            end
            OP_M: begin
                w_opa = $signed({{(OPND_W-DT_BITS){1'b0}}, r_dt});
                w_opb = OPND_W'(r_p11);
            end
            OP_ACC_P10: begin
                w_opa = $signed({{(OPND_W-DT_BITS){1'b0}}, r_dt});
                w_opb = OPND_W'(r_p10);
            end
            OP_ACC_M: begin
                w_opa = $signed({{(OPND_W-DT_BITS){1'b0}}, r_dt});
                w_opb = r_m;
            end
            OP_DT2: begin
                w_opa = $signed({{(OPND_W-DT_BITS){1'b0}}, r_dt});
                w_opb = $signed({{(OPND_W-DT_BITS){1'b0}}, r_dt});
            end
            OP_Q: begin
                w_opa = $signed({{(OPND_W-DT2_W){1'b0}}, r_dt2});
                w_opb = $signed({{(OPND_W-VAR_W){1'b0}}, r_gyro});
            end
            default: begin
                w_opa = '0;
                w_opb = '0;
            end
        endcase
    end

    // value to be clipped in the current step: innovation in idle, signed quotient, use-step result
    always_comb begin
        w_sum = '0;
        case (r_state)
            ST_IDLE: w_sum = WIDE_W'(i_measured_angle) - WIDE_W'(r_pa);
            ST_DIV_END: w_sum = r_neg ? -w_qx : w_qx;
            ST_USE: begin
                unique case (r_op)
                    OP_ANG:     w_sum = WIDE_W'(r_pa) + WIDE_W'(w_r16);
                    OP_BIAS:    w_sum = WIDE_W'(r_pb) + WIDE_W'(w_r16);
                    OP_P00:     w_sum = WIDE_W'(r_c00) - WIDE_W'(w_r16);
                    OP_P01:     w_sum = WIDE_W'(r_c01) - WIDE_W'(w_r16);
                    OP_P10:     w_sum = WIDE_W'(r_c10) - WIDE_W'(w_r16);
                    OP_P11:     w_sum = WIDE_W'(r_c11) - WIDE_W'(w_r16);
                    OP_PRED:    w_sum = WIDE_W'(r_ang) + WIDE_W'(w_r24);
                    OP_M:       w_sum = WIDE_W'(r_p10) - WIDE_W'(w_r24);
                    OP_ACC_P10: w_sum = '0;
                    OP_ACC_M:   w_sum = '0;
                    OP_DT2:     w_sum = '0;
                    OP_Q:       w_sum = WIDE_W'(w_acc_q);
                    default:    w_sum = '0;
                endcase
            end
            default: w_sum = '0;
        endcase
    end

    assign w_st = sat32(w_sum);

    // datapath next values
    always_comb begin
        n_op     = r_op;
        n_pa     = r_pa;
        n_pb     = r_pb;
        n_c00    = r_c00;
        n_c01    = r_c01;
        n_c10    = r_c10;
        n_c11    = r_c11;
        n_g0     = r_g0;
        n_g1     = r_g1;
        n_d      = r_d;
        n_u      = r_u;
        n_ang    = r_ang;
        n_bias   = r_bias;
        n_p00    = r_p00;
        n_p01    = r_p01;
        n_p10    = r_p10;
        n_p11    = r_p11;
        n_m      = r_m;
        n_dt2    = r_dt2;
        n_acc    = r_acc;
        n_sat    = r_sat;
        n_rem    = r_rem;
        n_den    = r_den;
        n_quo    = r_quo;
        n_cnt    = r_cnt;
        n_neg    = r_neg;
        n_div_g1 = r_div_g1;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_command == CMD_INIT) begin
                        n_pa   = '0;
                        n_pb   = r_ibias;
                        n_c00  = t_word'(1) <<< FRAC_BITS;
                        n_c01  = '0;
                        n_c10  = '0;
                        n_c11  = $signed({1'b0, r_gyro});
                        n_ang  = '0;
                        n_bias = r_ibias;
                        n_sat  = 1'b0;
                    end else begin
                        n_u      = i_gyro_rate;
                        n_d      = w_st.val;
                        n_op     = OP_ANG;
                        n_rem    = '0;
                        n_cnt    = '0;
                        n_den    = w_s[WORD_W-1:0];
                        n_neg    = r_c00[WORD_W-1];
                        n_quo    = {(r_c00[WORD_W-1] ? -r_c00 : r_c00), {FRAC_BITS{1'b0}}};
                        n_div_g1 = 1'b0;
                        if (w_s_pos) begin
                            n_sat = w_st.flag;
                        end else begin
                            n_g0  = '0;
                            n_g1  = '0;
                            n_sat = 1'b1;
                        end
                    end
                end
            end
            ST_DIV: begin
                n_rem = w_ge ? WORD_W'(w_t - {1'b0, r_den}) : w_t[WORD_W-1:0];
                n_quo = {r_quo[NUM_W-2:0], w_ge};
                n_cnt = r_cnt + CNT_W'(1);
            end
            ST_DIV_END: begin
                n_sat = r_sat | w_st.flag;
                if (r_div_g1) begin
                    n_g1 = w_st.val;
                end else begin
                    n_g0     = w_st.val;
                    n_div_g1 = 1'b1;
                    n_rem    = '0;
                    n_cnt    = '0;
                    n_neg    = r_c10[WORD_W-1];
                    n_quo    = {(r_c10[WORD_W-1] ? -r_c10 : r_c10), {FRAC_BITS{1'b0}}};
                end
            end
            ST_MUL: begin
                n_sat = r_sat;
            end
            ST_USE: begin
                n_op  = t_op'(r_op + 4'd1);
                n_sat = r_sat | w_st.flag;
                unique case (r_op)
                    OP_ANG:  n_ang  = w_st.val;
                    OP_BIAS: n_bias = w_st.val;
                    OP_P00:  n_p00  = w_st.val;
                    OP_P01:  n_p01  = w_st.val;
                    OP_P10:  n_p10  = w_st.val;
                    OP_P11:  n_p11  = w_st.val;
                    OP_PRED: begin
                        n_pa = w_st.val;
                        n_pb = r_bias;
                    end
                    OP_M: begin
                        n_m   = OPND_W'(r_p01) - OPND_W'(w_r24);
                        n_c10 = w_st.val;
                    end
                    OP_ACC_P10: n_acc = ACC_W'(r_p00) - ACC_W'(w_r24);
                    OP_ACC_M:   n_acc = r_acc - ACC_W'(w_r24);
                    OP_DT2:     n_dt2 = w_r24[DT2_W-1:0];
                    OP_Q: begin
                        n_c00 = w_st.val;
                        n_c01 = w_st_m.val;
                        n_c11 = r_p11;
                        n_sat = r_sat | w_st.flag | w_st_m.flag;
                    end
                    default: n_op = r_op;
                endcase
            end
            ST_DONE: begin
                n_sat = r_sat;
            end
            default: n_sat = r_sat;
        endcase
    end

    // control, configuration and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= OP_ANG;
            r_meas  <= VAR_W'(65536);
            r_gyro  <= VAR_W'(65536);
            r_dt    <= DT_BITS'(41943);
            r_ibias <= '0;
            r_pa    <= '0;
            r_pb    <= '0;
            r_c00   <= '0;
            r_c01   <= '0;
            r_c10   <= '0;
            r_c11   <= '0;
            r_cnt   <= '0;
            r_div_g1 <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_pa     <= n_pa;
            r_pb     <= n_pb;
            r_c00    <= n_c00;
            r_c01    <= n_c01;
            r_c10    <= n_c10;
            r_c11    <= n_c11;
            r_cnt    <= n_cnt;
            r_div_g1 <= n_div_g1;
            if (w_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MEAS_VAR: r_meas  <= i_cfg_data[VAR_W-1:0];
                    CFG_GYRO_VAR: r_gyro  <= i_cfg_data[VAR_W-1:0];
                    CFG_DT:       r_dt    <= i_cfg_data[DT_BITS-1:0];
                    CFG_BIAS:     r_ibias <= $signed(i_cfg_data);
                    default:      r_ibias <= r_ibias;
                endcase
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_g0   <= n_g0;
        r_g1   <= n_g1;
        r_d    <= n_d;
        r_u    <= n_u;
        r_ang  <= n_ang;
        r_bias <= n_bias;
        r_p00  <= n_p00;
        r_p01  <= n_p01;
        r_p10  <= n_p10;
        r_p11  <= n_p11;
        r_m    <= n_m;
        r_dt2  <= n_dt2;
        r_acc  <= n_acc;
        r_sat  <= n_sat;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_quo  <= n_quo;
        r_neg  <= n_neg;
        r_prod <= w_opa * w_opb;
    end

endmodule

// ===== sv/agkf_checker.sv =====
// agkf_checker: port-level assertions for the kalman filter top level, bound to it below
// depends on agkf_pkg and angle_gyro_bias_kalman_filter_top

module agkf_checker
    import agkf_pkg::*;
(
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_in_valid,
    input logic  o_in_stall,
    input logic  i_command,
    input logic  o_out_valid,
    input logic  i_out_stall,
    input t_word o_est_angle,
    input t_word o_est_bias,
    input logic  o_saturated
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_est_angle)
            && $stable(o_est_bias) && $stable(o_saturated)))
        else $error("stalled result changed");

    // one transaction in flight
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while busy");

    a_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while result pending");

    // initialize answers on the next cycle with a clean zero angle
    a_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_command == CMD_INIT)
            |=> (o_out_valid && !o_saturated && o_est_angle == '0))
        else $error("initialize result wrong");

    // exactly one result per transaction
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall) |=> !o_out_valid)
        else $error("result repeated");

endmodule

bind angle_gyro_bias_kalman_filter_top agkf_checker u_agkf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_command   (i_command),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_est_angle (o_est_angle),
    .o_est_bias  (o_est_bias),
    .o_saturated (o_saturated)
);
